FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: hw/rtl/alle_pkg.sv
// ----------------------------------------------------------------------------
// Linked list engine package
// Field widths, action codes and status codes of the linked list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alle_pkg;

	// Widths of the transaction fields.
	localparam int ACTION_W  = 2;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int ELEMENT_W = 32;

	// Action codes carried on the command channel.
	typedef enum logic [ACTION_W-1:0] {
		ACT_INS_HEAD = 2'd0,
		ACT_INS_TAIL = 2'd1,
		ACT_DISPLAY  = 2'd2
	} action_t;

	// Status codes carried on the response channel.
	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_ELEMENT  = 2'd2,
		STAT_EMPTY    = 2'd3
	} status_t;

endpackage

FILE: hw/rtl/alle_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one action and its data word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface alle_cmd_if;
	logic                                valid;
	logic                                ready;
	logic        [alle_pkg::ACTION_W-1:0] action;
	logic signed [alle_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

FILE: hw/rtl/alle_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one status, element word and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface alle_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic        [alle_pkg::STATUS_W-1:0]  status;
	logic signed [alle_pkg::ELEMENT_W-1:0] element;
	logic                                 last;

	modport source (output valid, output status, output element, output last, input ready);
	modport sink   (input valid, input status, input element, input last, output ready);
endinterface

FILE: hw/rtl/alle_node_store.sv
// ----------------------------------------------------------------------------
// Node store
// Data and link memories of the list nodes, one write port each and a
// shared registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alle_node_store #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	parameter int IDX_W      = 6,
	parameter int LINK_W     = 7
) (
	input  logic                  clk,
	input  logic                  data_we,
	input  logic [IDX_W-1:0]      data_waddr,
	input  logic [DATA_WIDTH-1:0] data_wdata,
	input  logic                  link_we,
	input  logic [IDX_W-1:0]      link_waddr,
	input  logic [LINK_W-1:0]     link_wdata,
	input  logic [IDX_W-1:0]      raddr,
	output logic [DATA_WIDTH-1:0] data_rdata,
	output logic [LINK_W-1:0]     link_rdata
);

	logic [DATA_WIDTH-1:0] data_mem [DEPTH];
	logic [LINK_W-1:0]     link_mem [DEPTH];

	// Data memory: one write, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end
		data_rdata <= data_mem[raddr];
	end

	// Link memory: one write, one registered read per cycle.
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rdata <= link_mem[raddr];
	end

endmodule

FILE: hw/rtl/array_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// Linked list engine core
// Singly linked list kept in a node store, with insert at head, insert at
// tail and display of the whole list.
//
//   Channel  Direction  Fields                    Transaction
//   cmd      in         action, value             one action
//   rsp      out        status, element, last     one result
//
// An insert at head needs no walk. An insert at tail walks to the last
// node and a display walks the whole list; the walk visits one node per
// cycle through the registered read port of the node store.
// Nodes are handed out in index order, so the free list is a fill count and
// every link is written when its node is allocated; reset needs no pass.
// The command channel is ready only between actions. The response register
// lets an action start while the last result still waits; a stalled
// response holds the display walk in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module array_linked_list_engine_core #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	alle_cmd_if.sink      cmd,
	alle_rsp_if.source    rsp
);

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int LINK_W = IDX_W + 1;
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
	localparam logic [LINK_W-1:0] NULL_LINK = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_TAIL,
		S_DISP,
		S_OUT
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            fill_q;
	logic [LINK_W-1:0]           head_q;
	logic [IDX_W-1:0]            cur_q;
	logic [IDX_W-1:0]            tail_idx_q;
	alle_pkg::status_t           pend_status_q;
	logic                        rsp_valid_q;
	logic [alle_pkg::STATUS_W-1:0]  rsp_status_q;
	logic [alle_pkg::ELEMENT_W-1:0] rsp_element_q;
	logic                        rsp_last_q;

	logic                  cmd_fire;
	logic                  slot_free;
	logic                  rsp_load;
	logic                  full;
	logic                  head_null;
	logic                  link_null;
	logic                  is_insert;
	logic                  ins_ok;
	logic [IDX_W-1:0]      new_idx;
	logic [IDX_W-1:0]      rd_addr;
	logic signed [63:0]    value_wide;
	logic signed [63:0]    elem_wide;
	logic                  data_we;
	logic                  link_we;
	logic [IDX_W-1:0]      link_waddr;
	logic [LINK_W-1:0]     link_wdata;
	logic [DATA_WIDTH-1:0] data_rd;
	logic [LINK_W-1:0]     link_rd;

	// Handshake and status decode.
	assign cmd.ready   = (state_q == S_IDLE);
	assign cmd_fire    = cmd.valid && cmd.ready;
	assign slot_free   = !rsp_valid_q || rsp.ready;
	assign rsp_load    = ((state_q == S_DISP) || (state_q == S_OUT)) && slot_free;
	assign full        = (fill_q == FULL_CNT);
	assign head_null   = head_q[IDX_W];
	assign link_null   = link_rd[IDX_W];
	assign new_idx     = fill_q[IDX_W-1:0];
	assign is_insert   = (cmd.action == alle_pkg::ACT_INS_HEAD) ||
	                     (cmd.action == alle_pkg::ACT_INS_TAIL);
	assign ins_ok      = cmd_fire && is_insert && !full;

	// Sign handling of stored and emitted words.
	assign value_wide  = 64'(cmd.value);
	assign elem_wide   = 64'(signed'(data_rd));

	// The data word of a new node is written when the command is accepted.
	assign data_we     = ins_ok;

	// Link writes: the new node at acceptance, the old tail at the walk's end.
	always_comb begin
		link_we    = 1'b0;
		link_waddr = new_idx;
		link_wdata = NULL_LINK;
		if (ins_ok) begin
			link_we = 1'b1;
			if (cmd.action == alle_pkg::ACT_INS_HEAD) begin
				link_wdata = head_q;
			end
		end else if (state_q == S_TAIL && link_null) begin
			link_we    = 1'b1;
			link_waddr = cur_q;
			link_wdata = {1'b0, tail_idx_q};
		end
	end

	// Read address: the head when a walk starts, the next node as it advances.
	always_comb begin
		unique case (state_q)
			S_TAIL: begin
				rd_addr = link_null ? cur_q : link_rd[IDX_W-1:0];
			end
			S_DISP: begin
				rd_addr = (slot_free && !link_null) ? link_rd[IDX_W-1:0] : cur_q;
			end
			default: begin
				rd_addr = head_q[IDX_W-1:0];
			end
		endcase
	end

	alle_node_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.IDX_W      (IDX_W),
		.LINK_W     (LINK_W)
	) u_store (
		.clk        (clk),
		.data_we    (data_we),
		.data_waddr (new_idx),
		.data_wdata (value_wide[DATA_WIDTH-1:0]),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.raddr      (rd_addr),
		.data_rdata (data_rd),
		.link_rdata (link_rd)
	);

	// Sequencer, list registers and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			head_q        <= NULL_LINK;
			cur_q         <= '0;
			tail_idx_q    <= '0;
			pend_status_q <= alle_pkg::STAT_INSERTED;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= '0;
			rsp_element_q <= '0;
			rsp_last_q    <= 1'b0;
		end else begin
			cur_q <= rd_addr;
			if (rsp_valid_q && rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						unique case (cmd.action)
							alle_pkg::ACT_INS_HEAD: begin
								state_q <= S_OUT;
								if (full) begin
									pend_status_q <= alle_pkg::STAT_FULL;
								end else begin
									pend_status_q <= alle_pkg::STAT_INSERTED;
									head_q        <= {1'b0, new_idx};
									fill_q        <= fill_q + 1'b1;
								end
							end
							alle_pkg::ACT_INS_TAIL: begin
								tail_idx_q <= new_idx;
								if (full) begin
									pend_status_q <= alle_pkg::STAT_FULL;
									state_q       <= S_OUT;
								end else begin
									pend_status_q <= alle_pkg::STAT_INSERTED;
									fill_q        <= fill_q + 1'b1;
									if (head_null) begin
										head_q  <= {1'b0, new_idx};
										state_q <= S_OUT;
									end else begin
										state_q <= S_TAIL;
									end
								end
							end
							alle_pkg::ACT_DISPLAY: begin
								if (head_null) begin
									pend_status_q <= alle_pkg::STAT_EMPTY;
									state_q       <= S_OUT;
								end else begin
									state_q <= S_DISP;
								end
							end
							default: begin
								// The unused action code is dropped.
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_TAIL: begin
					if (link_null) begin
						pend_status_q <= alle_pkg::STAT_INSERTED;
						state_q       <= S_OUT;
					end
				end
				S_DISP: begin
					if (slot_free) begin
						rsp_valid_q   <= 1'b1;
						rsp_status_q  <= alle_pkg::STAT_ELEMENT;
						rsp_element_q <= elem_wide[alle_pkg::ELEMENT_W-1:0];
						rsp_last_q    <= link_null;
						if (link_null) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_OUT: begin
					if (slot_free) begin
						rsp_valid_q   <= 1'b1;
						rsp_status_q  <= pend_status_q;
						rsp_element_q <= '0;
						rsp_last_q    <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.status  = rsp_status_q;
	assign rsp.element = rsp_element_q;
	assign rsp.last    = rsp_last_q;

	// The fill count never passes the store size.
	`ASSERT_NEVER(a_fill_bound, clk, arst_n, fill_q > FULL_CNT)
	// An accepted insert into a store with room allocates exactly one node.
	`ASSERT_PROP(a_fill_step, clk, arst_n, ins_ok |=> (fill_q == $past(fill_q) + 1'b1))
	// A tail walk only visits allocated nodes.
	`ASSERT_PROP(a_walk_alloc, clk, arst_n, (state_q == S_TAIL) |-> (CNT_W'(cur_q) < fill_q))
	// A display walk runs only over a list that has a head.
	`ASSERT_PROP(a_disp_head, clk, arst_n, (state_q == S_DISP) |-> (!head_null && fill_q != '0))

endmodule
